// ===== hdl/rc6_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc6_pkg
// shared types and constants of the rc6-32 block cipher
// ----------------------------------------------------------------------------
package rc6_pkg;

  localparam logic [31:0] MagicP = 32'hB7E15163;
  localparam logic [31:0] MagicQ = 32'h9E3779B9;
  localparam logic [4:0]  LogW   = 5'd5;

  // command codes on cmd_i
  typedef enum logic [1:0] {
    CMD_EXPAND  = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // register indexes (byte address is 8 times the index)
  localparam logic [2:0] RegKeyLo  = 3'd0;
  localparam logic [2:0] RegKeyMid = 3'd1;
  localparam logic [2:0] RegKeyHi  = 3'd2;
  localparam logic [2:0] RegKeyTop = 3'd3;
  localparam logic [2:0] RegKeyLen = 3'd4;

  localparam logic [5:0] KeyLenReset = 6'd16;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_ADJ      = 11'b000_0000_0010,
    S_RND_T    = 11'b000_0000_0100,
    S_RND_U    = 11'b000_0000_1000,
    S_RND_A    = 11'b000_0001_0000,
    S_RND_C    = 11'b000_0010_0000,
    S_EXP_INIT = 11'b000_0100_0000,
    S_EXP_RD   = 11'b000_1000_0000,
    S_EXP_A    = 11'b001_0000_0000,
    S_EXP_B    = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_e;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

endpackage

// ===== hdl/rc6_block_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc6_block_cipher
// rc6-32 block cipher with key expansion, encrypt and decrypt on one datapath
// ----------------------------------------------------------------------------
// usage
//   config: apb-style port, 64-bit registers at 8*index; the user must write the
//   four key byte registers and key_length while idle; the block does not check
//   input word: cmd_i plus word_a_i..word_d_i, taken on in_valid_i & in_ready_o;
//   cmd 0 expands the key into the round key table, 1 encrypts, 2 decrypts,
//   3 returns zeros
//   output word: out_a_o..out_d_o on out_valid_o, taken on out_ready_i;
//   zeros after expand
//   timing: a block runs through key adjust, the rounds, key adjust and done
//   before the next accept, and done waits while the output register is full;
//   the one shared x*(2x+1) multiplier and key table read port serve every round
//   expand fills the table, then makes three mixing passes of three steps per
//   entry each (read, update A, update B)
//   one word is in work at a time; in_ready_o is high only when idle
//   a finished word waits in the output register; a new input word is taken
//   meanwhile, and its result waits for the receiver before landing
//   reset: round key table reads as zeros (per-entry valid bits), key length
//   16, key bytes zero, no output pending
// ----------------------------------------------------------------------------
module rc6_block_cipher import rc6_pkg::*; #(
  parameter int ROUNDS        = 20,
  parameter int MAX_KEY_WORDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] word_a_i,
  input  logic [31:0] word_b_i,
  input  logic [31:0] word_c_i,
  input  logic [31:0] word_d_i,
  // output words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_a_o,
  output logic [31:0] out_b_o,
  output logic [31:0] out_c_o,
  output logic [31:0] out_d_o
);

  localparam int TL  = 2 * ROUNDS + 4;         // round key table length
  localparam int IW  = $clog2(TL);
  localparam int SW  = $clog2(3 * TL);
  localparam int RW  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int KW  = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int MKB = 4 * MAX_KEY_WORDS;       // max key bytes

  // ---------------- config registers ----------------
  logic [63:0] key_q [4];
  logic [5:0]  key_len_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) key_q[r] <= '0;
      key_len_q <= KeyLenReset;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        RegKeyLo:  key_q[0]  <= pwdata;
        RegKeyMid: key_q[1]  <= pwdata;
        RegKeyHi:  key_q[2]  <= pwdata;
        RegKeyTop: key_q[3]  <= pwdata;
        RegKeyLen: key_len_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      RegKeyLo:  prdata = key_q[0];
      RegKeyMid: prdata = key_q[1];
      RegKeyHi:  prdata = key_q[2];
      RegKeyTop: prdata = key_q[3];
      RegKeyLen: prdata = {58'd0, key_len_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------- key words loaded at expand start ----------------
  logic [5:0]  len_sat;
  logic [3:0]  nwords;
  logic [255:0] key_vec;
  logic [31:0] kw_load [MAX_KEY_WORDS];

  always_comb begin
    len_sat = (32'(key_len_q) > MKB) ? 6'(MKB) : key_len_q;
    nwords  = 4'((7'(len_sat) + 7'd3) >> 2);
    if (nwords == 4'd0) nwords = 4'd1;
    key_vec = {key_q[3], key_q[2], key_q[1], key_q[0]};
    for (int w = 0; w < MAX_KEY_WORDS; w++) begin
      for (int by = 0; by < 4; by++) begin
        kw_load[w][8*by +: 8] = (32'(4 * w + by) < 32'(len_sat)) ?
                                key_vec[8*(4*w+by) +: 8] : 8'd0;
      end
    end
  end

  // ---------------- sequencer state ----------------
  state_e      state_q, state_d;
  logic        dec_q, post_q;
  cmd_e        cmd_q;
  logic [1:0]  ph_q;
  logic [IW-1:0] i_q;
  logic [KW-1:0] j_q;
  logic [3:0]  nw_q;
  logic [SW-1:0] s_q;
  logic [RW-1:0] rnd_q;
  logic [31:0] wa_q, wb_q, wc_q, wd_q;
  logic [31:0] prod_q, t_q, u_q, key0_q, key1_q, acc_q;
  logic [31:0] kw_q [MAX_KEY_WORDS];
  logic        out_valid_q;
  logic [31:0] out_a_q, out_b_q, out_c_q, out_d_q;

  // ---------------- round key memory ----------------
  logic [31:0]   rk_mem [TL];
  logic [TL-1:0] rk_vld_q;
  logic [31:0]   rd_q;
  logic          rd_vld_q;
  logic [IW-1:0] rk_addr, wr_addr;
  logic          rk_we;
  logic [31:0]   rk_wdata, rk_val;

  assign rk_val = rd_vld_q ? rd_q : 32'd0;

  always_ff @(posedge clk_i) begin
    if (rk_we) rk_mem[wr_addr] <= rk_wdata;
    rd_q <= rk_mem[rk_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_vld_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rk_we) rk_vld_q[wr_addr] <= 1'b1;
      rd_vld_q <= rk_vld_q[rk_addr];
    end
  end

  // ---------------- shared datapath ----------------
  logic          use_hi;
  logic [IW-1:0] adj_base;
  logic [31:0]   mul_in, mul_out, u_now, exp_a, exp_sum, exp_b, a_rnd, c_rnd;
  logic [31:0]   kw_cur;

  assign use_hi   = dec_q ^ post_q;
  assign adj_base = use_hi ? IW'(TL - 2) : '0;
  assign mul_in   = (state_q == S_RND_U) ? wd_q : (dec_q ? wa_q : wb_q);
  assign mul_out  = mul_in * {mul_in[30:0], 1'b1};
  assign u_now    = rotl32(prod_q, LogW);
  assign kw_cur   = kw_q[j_q];
  assign exp_a    = rotl32(rk_val + wa_q + wb_q, 5'd3);
  assign exp_sum  = wa_q + wb_q;
  assign exp_b    = rotl32(kw_cur + exp_sum, exp_sum[4:0]);
  assign a_rnd    = dec_q ? (rotr32(wa_q - key0_q, u_now[4:0]) ^ t_q)
                          : (rotl32(wa_q ^ t_q, u_now[4:0]) + key0_q);
  assign c_rnd    = dec_q ? (rotr32(wc_q - key1_q, t_q[4:0]) ^ u_q)
                          : (rotl32(wc_q ^ u_q, t_q[4:0]) + key1_q);

  always_comb begin
    case (state_q)
      S_ADJ:   rk_addr = adj_base + IW'(ph_q[0]);
      S_RND_U: rk_addr = i_q + IW'(1);
      default: rk_addr = i_q;
    endcase
    rk_we    = (state_q == S_EXP_INIT) || (state_q == S_EXP_A);
    wr_addr  = i_q;
    rk_wdata = (state_q == S_EXP_INIT) ? acc_q : exp_a;
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(cmd_i))
            CMD_EXPAND:  state_d = S_EXP_INIT;
            CMD_ENCRYPT,
            CMD_DECRYPT: state_d = S_ADJ;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_ADJ:      if (ph_q == 2'd2) state_d = post_q ? S_DONE : S_RND_T;
      S_RND_T:    state_d = S_RND_U;
      S_RND_U:    state_d = S_RND_A;
      S_RND_A:    state_d = S_RND_C;
      S_RND_C:    state_d = (32'(rnd_q) == ROUNDS - 1) ? S_ADJ : S_RND_T;
      S_EXP_INIT: if (32'(i_q) == TL - 1) state_d = S_EXP_RD;
      S_EXP_RD:   state_d = S_EXP_A;
      S_EXP_A:    state_d = S_EXP_B;
      S_EXP_B:    state_d = (32'(s_q) == 3 * TL - 1) ? S_DONE : S_EXP_RD;
      S_DONE:     if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      nw_q        <= 4'd1;
      j_q         <= '0;
      rnd_q       <= '0;
    end else begin
      state_q <= state_d;
      // a result lands when the output register is free or being taken
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && cmd_e'(cmd_i) == CMD_EXPAND) begin
            nw_q <= nwords;
            j_q  <= '0;
          end
          rnd_q <= '0;
        end
        S_RND_C: rnd_q <= rnd_q + RW'(1);
        S_EXP_B: j_q <= (4'(j_q) == nw_q - 4'd1) ? '0 : j_q + KW'(1);
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q  <= cmd_e'(cmd_i);
        dec_q  <= (cmd_e'(cmd_i) == CMD_DECRYPT);
        post_q <= 1'b0;
        ph_q   <= 2'd0;
        wa_q   <= (cmd_e'(cmd_i) == CMD_EXPAND) ? '0 : word_a_i;
        wb_q   <= (cmd_e'(cmd_i) == CMD_EXPAND) ? '0 : word_b_i;
        wc_q   <= word_c_i;
        wd_q   <= word_d_i;
        i_q    <= '0;
        s_q    <= '0;
        acc_q  <= MagicP;
        if (cmd_e'(cmd_i) == CMD_EXPAND) begin
          for (int w = 0; w < MAX_KEY_WORDS; w++) kw_q[w] <= kw_load[w];
        end
      end
      S_ADJ: begin
        ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
        if (ph_q == 2'd1) begin
          if (use_hi) wa_q <= dec_q ? wa_q - rk_val : wa_q + rk_val;
          else        wb_q <= dec_q ? wb_q - rk_val : wb_q + rk_val;
        end
        if (ph_q == 2'd2) begin
          if (use_hi) wc_q <= dec_q ? wc_q - rk_val : wc_q + rk_val;
          else        wd_q <= dec_q ? wd_q - rk_val : wd_q + rk_val;
          i_q  <= dec_q ? IW'(TL - 4) : IW'(2);
        end
      end
      S_RND_T: begin
        prod_q <= mul_out;
        if (dec_q) begin
          // decrypt rotates the words before the round
          wa_q <= wd_q;
          wb_q <= wa_q;
          wc_q <= wb_q;
          wd_q <= wc_q;
        end
      end
      S_RND_U: begin
        t_q    <= rotl32(prod_q, LogW);
        prod_q <= mul_out;
        key0_q <= rk_val;
      end
      S_RND_A: begin
        u_q    <= u_now;
        wa_q   <= a_rnd;
        key1_q <= rk_val;
      end
      S_RND_C: begin
        i_q <= dec_q ? i_q - IW'(2) : i_q + IW'(2);
        if (dec_q) begin
          wc_q <= c_rnd;
        end else begin
          wa_q <= wb_q;
          wb_q <= c_rnd;
          wc_q <= wd_q;
          wd_q <= wa_q;
        end
        if (32'(rnd_q) == ROUNDS - 1) post_q <= 1'b1;
      end
      S_EXP_INIT: begin
        acc_q <= acc_q + MagicQ;
        i_q   <= (32'(i_q) == TL - 1) ? '0 : i_q + IW'(1);
      end
      S_EXP_A: wa_q <= exp_a;
      S_EXP_B: begin
        wb_q      <= exp_b;
        kw_q[j_q] <= exp_b;
        i_q       <= (32'(i_q) == TL - 1) ? '0 : i_q + IW'(1);
        s_q       <= s_q + SW'(1);
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          if (cmd_q == CMD_ENCRYPT || cmd_q == CMD_DECRYPT) begin
            out_a_q <= wa_q;
            out_b_q <= wb_q;
            out_c_q <= wc_q;
            out_d_q <= wd_q;
          end else begin
            out_a_q <= '0;
            out_b_q <= '0;
            out_c_q <= '0;
            out_d_q <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_a_o     = out_a_q;
  assign out_b_o     = out_b_q;
  assign out_c_o     = out_c_q;
  assign out_d_o     = out_d_q;

  // ---------------- assertions ----------------
  // an accepted word always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted word did not start work");

  // key word index stays inside the key length in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (4'(j_q) < nw_q))
    else $error("key word index out of range");

  // a result lands only from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("output raised outside done state");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for rc6_block_cipher: key setup over the register port,
// expand / encrypt / decrypt / unused-command words with random gaps on both sides, and each
// result checked against an in-bench cipher model
// ----------------------------------------------------------------------------
module tb;
  import rc6_pkg::*;

  localparam int NumRounds = 20;
  localparam int TableLen  = 2 * NumRounds + 4;
  localparam int KeyWords  = 8;
  localparam int StallLimit = 3000;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] a, b, c, d;
  } block_t;

  typedef struct {
    logic [31:0] a, b, c, d;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [31:0] word_a_i = '0, word_b_i = '0, word_c_i = '0, word_d_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] out_a_o, out_b_o, out_c_o, out_d_o;

  rc6_block_cipher dut (.*);

  always #10 clk_i = ~clk_i;

  // model copy of the cipher state and the key registers
  logic [31:0] sched[TableLen];
  logic [31:0] key_mix[KeyWords];
  logic [63:0] key_reg[4];
  logic [5:0]  key_len;

  block_t  send_q[$];
  result_t cipher_out_q[$];
  int      fail_count = 0;
  int      idle_max = 4;   // upper bound of random gaps, 0 for back-to-back
  int      quiet_cycles = 0;

  function automatic logic [31:0] rol(logic [31:0] x, logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
  endfunction

  function automatic logic [31:0] ror(logic [31:0] x, logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    return (s == 0) ? x : ((x >> s) | (x << (32 - s)));
  endfunction

  function automatic logic [31:0] square_mix(logic [31:0] x);
    logic [31:0] p;
    p = x * (2 * x + 1);
    return rol(p, 5);
  endfunction

  // key schedule: load key words, fill table, three mixing passes
  task automatic expand_schedule();
    int len, nw, i, j;
    logic [31:0] ra, rb;
    len = (key_len > 32) ? 32 : key_len;
    nw = (len + 3) / 4;
    if (nw == 0) nw = 1;
    foreach (key_mix[k]) key_mix[k] = '0;
    for (int k = 0; k < len; k++)
      key_mix[k / 4] |= 32'(key_reg[k / 8][8 * (k % 8) +: 8]) << (8 * (k % 4));
    sched[0] = MagicP;
    for (int k = 1; k < TableLen; k++) sched[k] = sched[k - 1] + MagicQ;
    ra = '0;
    rb = '0;
    i = 0;
    j = 0;
    for (int s = 0; s < 3 * TableLen; s++) begin
      ra = rol(sched[i] + ra + rb, 3);
      sched[i] = ra;
      rb = rol(key_mix[j] + ra + rb, ra + rb);
      key_mix[j] = rb;
      i = (i + 1) % TableLen;
      j = (j + 1) % nw;
    end
  endtask

  task automatic predict_cipher(input block_t blk, output result_t res);
    logic [31:0] a, b, c, d, t, u, x;
    res = '{default: '0};
    case (blk.cmd)
      CMD_EXPAND: expand_schedule();
      CMD_ENCRYPT: begin
        a = blk.a;
        b = blk.b + sched[0];
        c = blk.c;
        d = blk.d + sched[1];
        for (int i = 2; i <= 2 * NumRounds; i += 2) begin
          t = square_mix(b);
          u = square_mix(d);
          a = rol(a ^ t, u) + sched[i];
          c = rol(c ^ u, t) + sched[i + 1];
          x = a; a = b; b = c; c = d; d = x;
        end
        res = '{a + sched[2 * NumRounds + 2], b, c + sched[2 * NumRounds + 3], d};
      end
      CMD_DECRYPT: begin
        a = blk.a - sched[2 * NumRounds + 2];
        b = blk.b;
        c = blk.c - sched[2 * NumRounds + 3];
        d = blk.d;
        for (int i = 2 * NumRounds; i >= 2; i -= 2) begin
          x = d; d = c; c = b; b = a; a = x;
          u = square_mix(d);
          t = square_mix(b);
          c = ror(c - sched[i + 1], t) ^ u;
          a = ror(a - sched[i], u) ^ t;
        end
        res = '{a, b - sched[0], c, d - sched[1]};
      end
      default: ;  // unused command gives zeros, state untouched
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("tb: mismatch %s expected %08h got %08h at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  // driver: one input word at a time, random gap drawn per word
  int     send_gap = 0;
  block_t cur_blk;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_cipher(cur_blk, res);
        cipher_out_q.push_back(res);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (send_q.size() > 0) begin
          cur_blk = send_q.pop_front();
          cmd_i <= cur_blk.cmd;
          word_a_i <= cur_blk.a;
          word_b_i <= cur_blk.b;
          word_c_i <= cur_blk.c;
          word_d_i <= cur_blk.d;
          in_valid_i <= 1'b1;
          send_gap <= $urandom_range(0, idle_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word, stalls the receiver at random
  int recv_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int      stall_next;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall <= 0;
    end else begin
      stall_next = recv_stall;
      if (out_valid_o && out_ready_i) begin
        if (cipher_out_q.size() == 0) begin
          $display("tb: result word with nothing expected at %0t", $realtime);
          fail_count++;
        end else begin
          want = cipher_out_q.pop_front();
          if (out_a_o !== want.a) report("out_a", want.a, out_a_o);
          if (out_b_o !== want.b) report("out_b", want.b, out_b_o);
          if (out_c_o !== want.c) report("out_c", want.c, out_c_o);
          if (out_d_o !== want.d) report("out_d", want.d, out_d_o);
        end
        stall_next = $urandom_range(0, idle_max);
      end
      if (stall_next > 0) begin
        recv_stall <= stall_next - 1;
        out_ready_i <= 1'b0;
      end else begin
        recv_stall <= 0;
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles where neither channel moves and the register port is idle
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // register write: setup then access cycle, model updated with it
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegKeyLen) key_len = value[5:0];
    else key_reg[idx] = value;
  endtask

  task automatic load_key(input logic [63:0] lo, mid, hi, top, input logic [5:0] len);
    reg_write(RegKeyLo, lo);
    reg_write(RegKeyMid, mid);
    reg_write(RegKeyHi, hi);
    reg_write(RegKeyTop, top);
    reg_write(RegKeyLen, {58'd0, len});
  endtask

  task automatic queue_block(input cmd_e cmd, input logic [31:0] a, b, c, d);
    block_t blk;
    blk = '{cmd, a, b, c, d};
    send_q.push_back(blk);
  endtask

  // idle point: everything sent and every result back
  task automatic drain();
    while (send_q.size() > 0 || in_valid_i || cipher_out_q.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    logic [31:0] pa, pb, pc, pd;
    int r;
    foreach (sched[k]) sched[k] = '0;
    foreach (key_mix[k]) key_mix[k] = '0;
    foreach (key_reg[k]) key_reg[k] = '0;
    key_len = KeyLenReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cipher on the all-zero table, unused command, extremes of the words
    queue_block(CMD_ENCRYPT, '0, '0, '0, '0);
    queue_block(CMD_DECRYPT, '1, '1, '1, '1);
    queue_block(CMD_NONE, '1, '1, '1, '1);
    // default key: sixteen zero bytes
    queue_block(CMD_EXPAND, '1, '1, '1, '1);
    queue_block(CMD_ENCRYPT, '0, '0, '0, '0);
    queue_block(CMD_ENCRYPT, '1, '1, '1, '1);
    queue_block(CMD_DECRYPT, 32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    drain();

    // zero-length key counts as one zero word
    load_key('1, '1, '1, '1, 6'd0);
    queue_block(CMD_EXPAND, '0, '0, '0, '0);
    queue_block(CMD_ENCRYPT, '1, '0, '1, '0);
    queue_block(CMD_DECRYPT, '0, '1, '0, '1);
    drain();
    // full 32 byte key, then an oversized length that saturates
    load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
             64'h1716151413121110, 64'h1f1e1d1c1b1a1918, 6'd32);
    queue_block(CMD_EXPAND, '0, '0, '0, '0);
    queue_block(CMD_ENCRYPT, '0, '0, '0, '0);
    queue_block(CMD_DECRYPT, '1, '1, '1, '1);
    drain();
    reg_write(RegKeyLen, 64'd63);
    queue_block(CMD_EXPAND, '0, '0, '0, '0);
    queue_block(CMD_ENCRYPT, 32'h8000_0001, '1, '0, 32'h7fff_fffe);
    queue_block(CMD_NONE, '0, '0, '0, '0);
    queue_block(CMD_DECRYPT, '0, '0, '0, '0);
    drain();

    // random phases: new key, expand, then mostly cipher traffic
    for (int ph = 0; ph < 9; ph++) begin
      idle_max = (ph % 3 == 1) ? 0 : 4;
      r = $urandom_range(0, 5);
      load_key(rand_key(), rand_key(), rand_key(), rand_key(),
               (r == 0) ? 6'd0 : (r == 1) ? 6'd32 : (r == 2) ? 6'd63 : 6'($urandom_range(0, 63)));
      queue_block(CMD_EXPAND, rand_word(), rand_word(), rand_word(), rand_word());
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        pa = rand_word();
        pb = rand_word();
        pc = rand_word();
        pd = rand_word();
        if (r < 3) queue_block(CMD_EXPAND, pa, pb, pc, pd);
        else if (r < 6) queue_block(CMD_NONE, pa, pb, pc, pd);
        else if (r < 50) queue_block(CMD_ENCRYPT, pa, pb, pc, pd);
        else queue_block(CMD_DECRYPT, pa, pb, pc, pd);
        // in even phases the sender holds off mid-phase until the pipe is empty
        if (n == 50 && ph % 2 == 0) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
